/* rtl/wrt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// wrt_pkg: shared types and helpers for the wave reflection tube step
// Fixed-point formats, sequencer states, cell control and the round and
// saturate helper used by every junction cell and the lip filter.
// ============================================================================
package wrt_pkg;

    localparam int COEF_W  = 16;
    localparam int PRES_W  = 24;
    localparam int ACC_W   = 48;
    localparam int FRAC_W  = 14;
    localparam int INDEX_W = 6;

    localparam logic signed [PRES_W-1:0] P_MAX = 24'sh7FFFFF;
    localparam logic signed [PRES_W-1:0] P_MIN = 24'sh800000;

    // Operation codes carried in the input tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_LIP_ATT   = 3'd0;
    localparam logic [2:0] REG_PREV_BACK = 3'd1;
    localparam logic [2:0] REG_INC_BACK  = 3'd2;
    localparam logic [2:0] REG_FEEDBACK  = 3'd3;
    localparam logic [2:0] REG_PREV_FWD  = 3'd4;
    localparam logic [2:0] REG_INC_FWD   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PH1,
        ST_PH2,
        ST_PH3
    } tick_state_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic                     load_en;
        logic [INDEX_W-1:0]       load_index;
        logic signed [COEF_W-1:0] load_refl;
        logic signed [COEF_W-1:0] load_att;
        logic                     ph1;
        logic                     ph2;
    } cell_ctl_t;

    typedef struct packed {
        logic signed [PRES_W-1:0] val;
        logic                     clip;
    } scaled_t;

    // Round half up by 2^-14, then saturate to 24 bits.
    function automatic scaled_t scale(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        scaled_t                 s;
        y = (x + ACC_W'(8192)) >>> FRAC_W;
        if (y > ACC_W'(P_MAX)) begin
            s.val  = P_MAX;
            s.clip = 1'b1;
        end
        else if (y < ACC_W'(P_MIN)) begin
            s.val  = P_MIN;
            s.clip = 1'b1;
        end
        else begin
            s.val  = y[PRES_W-1:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

endpackage

/* rtl/wave_reflection_tube_step.sv */
`timescale 1ns / 1ps
// ============================================================================
// wave_reflection_tube_step: lossy scattering tube with lip radiation
// Row of junction cells, lip filter, tick sequencer and output register.
// ============================================================================
// A load transaction (tuser 0) writes one section's coefficients and leaves
// the sequencer idle. A tick transaction (tuser 1) is accepted and then runs
// three phases of the cell row (attenuate, scatter, glottis return); the last
// phase waits for room in the output register, which holds the result until
// the downstream side takes it. The next transaction is accepted in the cycle after the result enters it.
module wave_reflection_tube_step
    import wrt_pkg::*;
#(
    parameter int SECTIONS = 44
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // section_index[5:0], reflection_coef[21:6], attenuation_coef[37:22],
    // glottal_forward_pressure[61:38], zero fill [63:62]
    input  logic [63:0]  s_tdata,
    // op[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // glottis_return_pressure[23:0], lip_incident_pressure[47:24],
    // lip_forward_pressure[71:48], lip_backward_pressure[95:72]
    output logic [95:0]  m_tdata,
    // saturated[0]
    output logic         m_tuser
);

    tick_state_t state_reg, state_next;

    logic signed [COEF_W-1:0] lip_att_reg, g_prev_back_reg, g_inc_back_reg;
    logic signed [COEF_W-1:0] g_fb_reg, g_prev_fwd_reg, g_inc_fwd_reg;
    logic signed [PRES_W-1:0] glot_reg, lb_reg, lipf_reg, lipb_reg, prev_reg;
    logic                     top_clip_reg;
    logic                     out_valid_reg;
    logic [95:0]              out_data_reg;
    logic                     out_sat_reg;

    logic                     accept;
    logic                     out_load;
    cell_ctl_t                ctl;

    logic signed [PRES_W-1:0] ba_v   [SECTIONS];
    logic signed [PRES_W-1:0] fa_v   [SECTIONS];
    logic signed [PRES_W-1:0] fw_v   [SECTIONS];
    logic                     fwc_v  [SECTIONS];
    logic signed [PRES_W-1:0] bw_v   [SECTIONS];
    logic signed [COEF_W-1:0] att_v  [SECTIONS];
    logic [SECTIONS-1:0]      clip_v;

    logic signed [ACC_W-1:0]  prod_lb, prod_ret, sum_lipb, sum_lipf;
    scaled_t                  sc_lb, sc_ret, sc_lipb, sc_lipf;
    logic signed [PRES_W-1:0] p_inc;

    assign accept = s_tvalid && s_tready;

    // Sequencer for the tick phases.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == OP_TICK))
                    state_next = ST_PH1;
            end
            ST_PH1:
                state_next = ST_PH2;
            ST_PH2:
                state_next = ST_PH3;
            ST_PH3:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign ctl.load_en    = accept && (s_tuser == OP_LOAD);
    assign ctl.load_index = s_tdata[5:0];
    assign ctl.load_refl  = s_tdata[21:6];
    assign ctl.load_att   = s_tdata[37:22];
    assign ctl.ph1        = (state_reg == ST_PH1);
    assign ctl.ph2        = (state_reg == ST_PH2);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lip_att_reg     <= 16'sd16384;
            g_prev_back_reg <= '0;
            g_inc_back_reg  <= '0;
            g_fb_reg        <= '0;
            g_prev_fwd_reg  <= '0;
            g_inc_fwd_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LIP_ATT:   lip_att_reg     <= cfg_data;
                REG_PREV_BACK: g_prev_back_reg <= cfg_data;
                REG_INC_BACK:  g_inc_back_reg  <= cfg_data;
                REG_FEEDBACK:  g_fb_reg        <= cfg_data;
                REG_PREV_FWD:  g_prev_fwd_reg  <= cfg_data;
                REG_INC_FWD:   g_inc_fwd_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Row of junction cells; the last one sees the attenuated lip wave.
    genvar k;
    generate
        for (k = 0; k < SECTIONS; k++)
        begin : g_cell
            logic signed [PRES_W-1:0] ba_nb, fw_nb;
            logic                     fwc_nb;
            if (k == SECTIONS - 1)
            begin : g_last
                assign ba_nb = lb_reg;
            end
            else
            begin : g_mid
                assign ba_nb = ba_v[k+1];
            end
            if (k == 0)
            begin : g_first
                assign fw_nb  = glot_reg;
                assign fwc_nb = 1'b0;
            end
            else
            begin : g_rest
                assign fw_nb  = fw_v[k-1];
                assign fwc_nb = fwc_v[k-1];
            end
            wrt_cell #(.K(k)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .ba_in       (ba_nb),
                .fw_in       (fw_nb),
                .fw_in_clip  (fwc_nb),
                .ba_out      (ba_v[k]),
                .fa_out      (fa_v[k]),
                .fw_out      (fw_v[k]),
                .fw_out_clip (fwc_v[k]),
                .bw_out      (bw_v[k]),
                .att_out     (att_v[k]),
                .clip        (clip_v[k])
            );
        end
    endgenerate

    // Lip filter and glottis return arithmetic.
    assign p_inc    = fa_v[SECTIONS-1];
    assign prod_lb  = lip_att_reg * lipb_reg;
    assign sc_lb    = scale(prod_lb);
    assign sum_lipb = g_prev_back_reg * prev_reg + g_inc_back_reg * p_inc
                    + g_fb_reg * lipb_reg;
    assign sum_lipf = g_prev_fwd_reg * prev_reg + g_inc_fwd_reg * p_inc
                    + g_fb_reg * lipf_reg;
    assign sc_lipb  = scale(sum_lipb);
    assign sc_lipf  = scale(sum_lipf);
    assign prod_ret = att_v[0] * bw_v[0];
    assign sc_ret   = scale(prod_ret);

    // Lip state, injected pressure and top-level clip flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glot_reg     <= '0;
            lb_reg       <= '0;
            lipf_reg     <= '0;
            lipb_reg     <= '0;
            prev_reg     <= '0;
            top_clip_reg <= 1'b0;
        end
        else
        begin
            if (accept && (s_tuser == OP_TICK))
                glot_reg <= s_tdata[61:38];
            if (ctl.ph1)
            begin
                lb_reg       <= sc_lb.val;
                top_clip_reg <= sc_lb.clip;
            end
            else if (ctl.ph2)
            begin
                lipb_reg     <= sc_lipb.val;
                lipf_reg     <= sc_lipf.val;
                prev_reg     <= p_inc;
                top_clip_reg <= top_clip_reg | sc_lipb.clip | sc_lipf.clip;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {lipb_reg, lipf_reg, prev_reg, sc_ret.val};
            out_sat_reg  <= top_clip_reg | sc_ret.clip | (|clip_v);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while a tick is in progress");
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_TICK)) |=> (state_reg == ST_PH1))
        else $error("tick transaction did not start the phase sequence");
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("load transaction started a tick");
    a_result_from_ph3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_PH3))
        else $error("result appeared outside the final phase");
`endif

endmodule

/* rtl/wrt_cell.sv */
`timescale 1ns / 1ps
// ============================================================================
// wrt_cell: one tube section with its far scattering junction
// Holds the section's waves and coefficients. Phase one attenuates both
// waves; phase two scatters at the far junction and hands the new forward
// wave to the next cell.
// ============================================================================
module wrt_cell
    import wrt_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctl_t                ctl,
    input  logic signed [PRES_W-1:0] ba_in,
    input  logic signed [PRES_W-1:0] fw_in,
    input  logic                     fw_in_clip,
    output logic signed [PRES_W-1:0] ba_out,
    output logic signed [PRES_W-1:0] fa_out,
    output logic signed [PRES_W-1:0] fw_out,
    output logic                     fw_out_clip,
    output logic signed [PRES_W-1:0] bw_out,
    output logic signed [COEF_W-1:0] att_out,
    output logic                     clip
);

    logic signed [PRES_W-1:0] fw_reg, bw_reg, fa_reg, ba_reg;
    logic signed [COEF_W-1:0] r_reg, a_reg;
    logic                     clip_reg;

    logic signed [ACC_W-1:0]  prod_f, prod_b, prod_r, sum_b, sum_f;
    logic signed [PRES_W:0]   diff;
    scaled_t                  sc_fa, sc_ba, sc_bw, sc_fw;

    // Attenuation products for phase one.
    assign prod_f = a_reg * fw_reg;
    assign prod_b = a_reg * bw_reg;
    assign sc_fa  = scale(prod_f);
    assign sc_ba  = scale(prod_b);

    // Junction: both outgoing waves share R * (fa - ba_next).
    assign diff   = (PRES_W+1)'(fa_reg) - (PRES_W+1)'(ba_in);
    assign prod_r = r_reg * diff;
    assign sum_b  = (ACC_W'(ba_in) <<< FRAC_W) + prod_r;
    assign sum_f  = (ACC_W'(fa_reg) <<< FRAC_W) + prod_r;
    assign sc_bw  = scale(sum_b);
    assign sc_fw  = scale(sum_f);

    // Coefficient store, written by load transactions.
    always_ff @(posedge clk)
    begin
        if (ctl.load_en && (32'(ctl.load_index) == K))
        begin
            r_reg <= ctl.load_refl;
            a_reg <= ctl.load_att;
        end
    end

    // Wave state and per-tick clip flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= '0;
            bw_reg   <= '0;
            fa_reg   <= '0;
            ba_reg   <= '0;
            clip_reg <= 1'b0;
        end
        else if (ctl.ph1)
        begin
            fa_reg   <= sc_fa.val;
            ba_reg   <= sc_ba.val;
            clip_reg <= sc_fa.clip | sc_ba.clip;
        end
        else if (ctl.ph2)
        begin
            bw_reg   <= sc_bw.val;
            fw_reg   <= fw_in;
            clip_reg <= clip_reg | sc_bw.clip | fw_in_clip;
        end
    end

    assign ba_out      = ba_reg;
    assign fa_out      = fa_reg;
    assign fw_out      = sc_fw.val;
    assign fw_out_clip = sc_fw.clip;
    assign bw_out      = bw_reg;
    assign att_out     = a_reg;
    assign clip        = clip_reg;

endmodule
